// ----- hw/rtl/ioset_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioset_pkg
// Shared types and constants for the insertion-ordered integer set core.
// ----------------------------------------------------------------------------
package ioset_pkg;

	// Default number of member slots.
	localparam int DEF_CAPACITY = 64;

	// Field widths of the request and response beats.
	localparam int VALUE_W = 32;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 7;

	// Operation codes carried by a request beat.
	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	// Sequencer states: wait for a request, compare in all cells, apply update.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic compare;
		logic add;
		logic remove;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/ioset_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioset_if
// Valid/ready channels for request and response beats of the set core.
// ----------------------------------------------------------------------------
interface ioset_req_if;
	logic                                valid;
	logic                                ready;
	logic [ioset_pkg::OP_W-1:0]          op;
	logic signed [ioset_pkg::VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface ioset_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic                            full_refused;
	logic [ioset_pkg::COUNT_W-1:0]   count;
	logic                            empty_res;

	modport source (output valid, output ok, output full_refused, output count,
		output empty_res, input ready);
	modport sink   (input valid, input ok, input full_refused, input count,
		input empty_res, output ready);
endinterface

// ----- hw/rtl/ioset_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioset_cell
// One member slot: holds a value, compares it with the broadcast key and
// takes its upper neighbor's value when a removal closes the gap.
// ----------------------------------------------------------------------------
module ioset_cell #(
	parameter int CAPACITY = ioset_pkg::DEF_CAPACITY,
	parameter int IDX      = 0
) (
	input  logic                                clk,
	input  ioset_pkg::cell_ctl_t                ctl,
	input  logic [ioset_pkg::VALUE_W-1:0]       key,
	input  logic [$clog2(CAPACITY+1)-1:0]       count,
	input  logic [$clog2(CAPACITY)-1:0]         slot,
	input  logic [ioset_pkg::VALUE_W-1:0]       upper_data,
	output logic [ioset_pkg::VALUE_W-1:0]       data,
	output logic                                match
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);
	localparam logic [IW-1:0] IDX_I  = IW'(IDX);

	logic [ioset_pkg::VALUE_W-1:0] data_q;
	logic                          match_q;
	logic                          in_use;

	// The slot is occupied when it lies below the member count.
	assign in_use = (IDX_C < count);

	// Registered compare against the key.
	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			match_q <= in_use && (data_q == key);
		end
	end

	// Append at the first free slot, or shift down above the removed slot.
	always_ff @(posedge clk) begin
		if (ctl.add && (IDX_C == count)) begin
			data_q <= key;
		end else if (ctl.remove && (IDX_I >= slot) && (IDX_P1 < count)) begin
			data_q <= upper_data;
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// ----- hw/rtl/insertion_ordered_int_set_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_ordered_int_set_core
// Set of distinct 32-bit integers kept in order of first membership.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on req carries op (add, remove, contains, clear) and value.
// Each request yields exactly one response beat on rsp with ok, full_refused,
// the member count after the operation and an empty flag.
// Members sit in a row of CAPACITY cells, packed from slot 0 upward. Every
// cell compares its value with the key in the compare step and registers
// the result; the update step then locates the matching slot, appends a new
// member at the end or shifts the cells above a removed member down by one,
// and loads the response register. A new request is taken only once the
// sequencer is back in its idle state, after the accept, compare and update
// steps of the previous one.
// A finished response waits in its output register; the next request is
// accepted meanwhile and then holds in its update step until the response
// register frees up when the receiver stalls.
// Reset empties the set and drops any pending response; slot contents are
// not cleared, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module insertion_ordered_int_set_core #(
	parameter int CAPACITY = ioset_pkg::DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	ioset_req_if.sink   req,
	ioset_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [CW-1:0] FULL_C = CW'(CAPACITY);

	ioset_pkg::state_t           state_q, state_nxt;
	ioset_pkg::op_t              op_q;
	logic [ioset_pkg::VALUE_W-1:0] key_q;
	logic [CW-1:0]               count_q, count_nxt;
	ioset_pkg::cell_ctl_t        ctl;
	logic                        compare_en, upd_en;

	logic [ioset_pkg::VALUE_W-1:0] cell_data  [CAPACITY];
	logic [ioset_pkg::VALUE_W-1:0] upper_data [CAPACITY];
	logic [CAPACITY-1:0]         match;
	logic                        found, full;
	logic [IW-1:0]               slot;
	logic                        ok_nxt, refused_nxt, do_add, do_remove;

	logic                        rsp_valid_q, ok_q, refused_q, empty_q;
	logic [ioset_pkg::COUNT_W-1:0] rsp_count_q;

	// Next-state logic of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ioset_pkg::ST_IDLE: begin
				if (req.valid) state_nxt = ioset_pkg::ST_CMP;
			end
			ioset_pkg::ST_CMP: begin
				state_nxt = ioset_pkg::ST_UPD;
			end
			ioset_pkg::ST_UPD: begin
				if (!rsp_valid_q || rsp.ready) state_nxt = ioset_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ioset_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req.ready  = 1'b0;
		compare_en = 1'b0;
		upd_en     = 1'b0;
		case (state_q)
			ioset_pkg::ST_IDLE: req.ready  = 1'b1;
			ioset_pkg::ST_CMP:  compare_en = 1'b1;
			ioset_pkg::ST_UPD:  upd_en     = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ioset_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the request beat.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= ioset_pkg::op_t'(req.op);
			key_q <= req.value;
		end
	end

	// Row of cells; each takes its upper neighbor's value on a removal.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_last
			assign upper_data[i] = cell_data[i];
		end else begin : g_mid
			assign upper_data[i] = cell_data[i+1];
		end
		ioset_cell #(
			.CAPACITY(CAPACITY),
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (key_q),
			.count     (count_q),
			.slot      (slot),
			.upper_data(upper_data[i]),
			.data      (cell_data[i]),
			.match     (match[i])
		);
	end

	// Locate the matching slot; values are distinct, so at most one cell hits.
	always_comb begin
		slot = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			slot = slot | (match[i] ? IW'(i) : '0);
		end
	end
	assign found = |match;
	assign full  = (count_q == FULL_C);

	// Outcome of the operation and the new member count.
	always_comb begin
		ok_nxt      = 1'b0;
		refused_nxt = 1'b0;
		do_add      = 1'b0;
		do_remove   = 1'b0;
		count_nxt   = count_q;
		case (op_q)
			ioset_pkg::OP_ADD: begin
				do_add      = !found && !full;
				refused_nxt = !found && full;
				ok_nxt      = do_add;
				if (do_add) count_nxt = count_q + CW'(1);
			end
			ioset_pkg::OP_REMOVE: begin
				do_remove = found;
				ok_nxt    = found;
				if (found) count_nxt = count_q - CW'(1);
			end
			ioset_pkg::OP_CONTAINS: begin
				ok_nxt = found;
			end
			default: begin
				ok_nxt    = 1'b1;
				count_nxt = '0;
			end
		endcase
	end

	assign ctl.compare = compare_en;
	assign ctl.add     = upd_en && do_add;
	assign ctl.remove  = upd_en && do_remove;

	// Member count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (upd_en) begin
			count_q <= count_nxt;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			ok_q        <= ok_nxt;
			refused_q   <= refused_nxt;
			rsp_count_q <= ioset_pkg::COUNT_W'(count_nxt);
			empty_q     <= (count_nxt == '0);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.full_refused = refused_q;
	assign rsp.count        = rsp_count_q;
	assign rsp.empty_res    = empty_q;

endmodule

// ----- hw/rtl/ioset_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioset_checker
// Port-level checks of the set core, bound to its top level.
// ----------------------------------------------------------------------------
module ioset_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_ok,
	input logic                          rsp_full_refused,
	input logic [ioset_pkg::COUNT_W-1:0] rsp_count
);

	// A stalled response beat stays valid.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	// A stalled response keeps its count.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_count))
		else $error("response count changed while stalled");

	// A refused add never reports success.
	a_refused_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_full_refused |-> !rsp_ok)
		else $error("response both refused and ok");

	// After a request beat the core is busy for the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in consecutive cycles");

endmodule

bind insertion_ordered_int_set_core ioset_checker u_ioset_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_full_refused(rsp.full_refused),
	.rsp_count       (rsp.count)
);

// ----- sim/insertion_ordered_int_set_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_ordered_int_set_core_tb
// Self-checking bench for the insertion-ordered integer set core.
// A short table of directed requests covers the empty set, the extreme values,
// duplicates, removal at the head, middle and tail, and clear. Random bursts
// follow. Some bursts fill the set past capacity; the others mix operations
// over small key pools. Every response beat is compared with a shadow copy of
// the set. Both channels idle at random, apart from one steady stretch.
// ----------------------------------------------------------------------------
module insertion_ordered_int_set_core_tb;

	localparam int CAP         = ioset_pkg::DEF_CAPACITY;
	localparam int RAND_BEATS  = 1950;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 10;

	// Expected content of one response beat.
	typedef struct packed {
		logic                          ok;
		logic                          full_refused;
		logic [ioset_pkg::COUNT_W-1:0] count;
		logic                          empty_res;
	} set_rsp_t;

	// One row of the directed table; typed rows carry a hand-written response.
	typedef struct packed {
		ioset_pkg::op_t op;
		logic [31:0]    value;
		logic           typed;
		set_rsp_t       want;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	logic clk = 1'b0;
	logic arst_n;

	ioset_req_if req_ch ();
	ioset_rsp_if rsp_ch ();

	insertion_ordered_int_set_core #(
		.CAPACITY(CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow set, pending responses and run bookkeeping.
	logic [31:0] set_members [$];
	set_rsp_t    pending_rsp [$];
	logic [31:0] key_pool [8];
	int unsigned beats_sent = 0;
	int unsigned errors     = 0;
	int unsigned cycles     = 0;
	logic        steady;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ioset_pkg::OP_CONTAINS, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b1}},
		'{ioset_pkg::OP_REMOVE,   32'h0000_0005, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b1}},
		'{ioset_pkg::OP_CLEAR,    32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd0, 1'b1}},
		'{ioset_pkg::OP_ADD,      32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd1, 1'b0}},
		'{ioset_pkg::OP_ADD,      32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd2, 1'b0}},
		'{ioset_pkg::OP_ADD,      32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd3, 1'b0}},
		'{ioset_pkg::OP_ADD,      32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd4, 1'b0}},
		'{ioset_pkg::OP_ADD,      32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd4, 1'b0}},
		'{ioset_pkg::OP_CONTAINS, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd4, 1'b0}},
		'{ioset_pkg::OP_CONTAINS, 32'h8000_0001, 1'b1, '{1'b0, 1'b0, 7'd4, 1'b0}},
		'{ioset_pkg::OP_REMOVE,   32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd3, 1'b0}},
		'{ioset_pkg::OP_CONTAINS, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd3, 1'b0}},
		'{ioset_pkg::OP_REMOVE,   32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd3, 1'b0}},
		'{ioset_pkg::OP_ADD,      32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd4, 1'b0}},
		'{ioset_pkg::OP_REMOVE,   32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd3, 1'b0}},
		'{ioset_pkg::OP_REMOVE,   32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd2, 1'b0}},
		'{ioset_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 1'b0, '0},
		'{ioset_pkg::OP_CONTAINS, 32'h0000_0000, 1'b0, '0},
		'{ioset_pkg::OP_CLEAR,    32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd0, 1'b1}},
		'{ioset_pkg::OP_ADD,      32'h5555_5555, 1'b0, '0},
		'{ioset_pkg::OP_REMOVE,   32'h5555_5555, 1'b1, '{1'b1, 1'b0, 7'd0, 1'b1}},
		'{ioset_pkg::OP_CLEAR,    32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd0, 1'b1}},
		'{ioset_pkg::OP_ADD,      32'hAAAA_AAAA, 1'b0, '0}
	};

	// Both channels run without idling over a stretch in the middle of the run.
	assign steady = (beats_sent >= 900) && (beats_sent < 1250);

	always #10 clk = ~clk;

	// Slot of a value in the shadow set, or -1 when it is absent.
	function automatic int slot_of(input logic [31:0] v);
		for (int i = 0; i < set_members.size(); i++) begin
			if (set_members[i] == v) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Applies one operation to the shadow set and returns the response it gives.
	function automatic set_rsp_t apply_set_op(input ioset_pkg::op_t op,
		input logic [31:0] v);
		set_rsp_t r;
		int       slot;
		r    = '0;
		slot = slot_of(v);
		case (op)
			ioset_pkg::OP_ADD: begin
				if (slot < 0) begin
					if (set_members.size() >= CAP) begin
						r.full_refused = 1'b1;
					end else begin
						set_members.push_back(v);
						r.ok = 1'b1;
					end
				end
			end
			ioset_pkg::OP_REMOVE: begin
				if (slot >= 0) begin
					set_members.delete(slot);
					r.ok = 1'b1;
				end
			end
			ioset_pkg::OP_CONTAINS: begin
				r.ok = (slot >= 0);
			end
			default: begin
				set_members.delete();
				r.ok = 1'b1;
			end
		endcase
		r.count     = ioset_pkg::COUNT_W'(set_members.size());
		r.empty_res = (set_members.size() == 0);
		return r;
	endfunction

	// Drives one request beat, then records its expected response on acceptance.
	task automatic send_beat(input ioset_pkg::op_t op, input logic [31:0] v,
		input logic typed, input set_rsp_t want);
		set_rsp_t r;
		while (!steady && $urandom_range(99) < 16) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		r = apply_set_op(op, v);
		pending_rsp.push_back(typed ? want : r);
		beats_sent++;
	endtask

	// Values mostly hit current members or a small pool, so hits are frequent.
	function automatic logic [31:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45 && set_members.size() != 0) begin
			return set_members[$urandom_range(set_members.size() - 1)];
		end else if (r < 75) begin
			return key_pool[$urandom_range(7)];
		end else if (r < 90) begin
			return $urandom;
		end
		case ($urandom_range(5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h1 << $urandom_range(31);
			default: return ~(32'h1 << $urandom_range(31));
		endcase
	endfunction

	task automatic mixed_burst();
		int unsigned    len;
		int unsigned    r;
		ioset_pkg::op_t op;
		len = $urandom_range(60, 10);
		foreach (key_pool[i]) begin
			key_pool[i] = $urandom;
		end
		for (int unsigned n = 0; n < len; n++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				op = ioset_pkg::OP_ADD;
			end else if (r < 65) begin
				op = ioset_pkg::OP_REMOVE;
			end else if (r < 95) begin
				op = ioset_pkg::OP_CONTAINS;
			end else begin
				op = ioset_pkg::OP_CLEAR;
			end
			send_beat(op, (op == ioset_pkg::OP_CLEAR) ? $urandom : pick_key(), 1'b0, '0);
		end
	endtask

	// Clear, fill past capacity, then poke at the full set.
	task automatic fill_burst();
		int unsigned tail;
		send_beat(ioset_pkg::OP_CLEAR, $urandom, 1'b0, '0);
		for (int n = 0; n < CAP + 4; n++) begin
			send_beat(ioset_pkg::OP_ADD, $urandom, 1'b0, '0);
		end
		send_beat(ioset_pkg::OP_ADD, set_members[$urandom_range(CAP - 1)], 1'b0, '0);
		send_beat(ioset_pkg::OP_CONTAINS, set_members[0], 1'b0, '0);
		send_beat(ioset_pkg::OP_CONTAINS, set_members[CAP - 1], 1'b0, '0);
		send_beat(ioset_pkg::OP_REMOVE, set_members[$urandom_range(CAP - 1)], 1'b0, '0);
		send_beat(ioset_pkg::OP_ADD, $urandom, 1'b0, '0);
		send_beat(ioset_pkg::OP_ADD, $urandom, 1'b0, '0);
		tail = $urandom_range(20, 4);
		for (int unsigned n = 0; n < tail; n++) begin
			send_beat($urandom_range(1) ? ioset_pkg::OP_REMOVE : ioset_pkg::OP_CONTAINS,
				pick_key(), 1'b0, '0);
		end
	endtask

	// Response monitor and randomly stalling receiver.
	always @(posedge clk) begin
		set_rsp_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected response beat ok=%b full_refused=%b count=%0d empty=%b",
					$time, rsp_ch.ok, rsp_ch.full_refused, rsp_ch.count, rsp_ch.empty_res);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_ch.ok !== exp_rsp.ok) begin
					errors++;
					$display("%0t: ok expected %b actual %b", $time, exp_rsp.ok, rsp_ch.ok);
				end
				if (rsp_ch.full_refused !== exp_rsp.full_refused) begin
					errors++;
					$display("%0t: full_refused expected %b actual %b", $time,
						exp_rsp.full_refused, rsp_ch.full_refused);
				end
				if (rsp_ch.count !== exp_rsp.count) begin
					errors++;
					$display("%0t: count expected %0d actual %0d", $time,
						exp_rsp.count, rsp_ch.count);
				end
				if (rsp_ch.empty_res !== exp_rsp.empty_res) begin
					errors++;
					$display("%0t: empty_res expected %b actual %b", $time,
						exp_rsp.empty_res, rsp_ch.empty_res);
				end
			end
		end
		rsp_ch.ready <= steady || ($urandom_range(99) >= 16);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[insertion_ordered_int_set_core] ERROR");
			$finish;
		end
	end

	// Reset, directed table, random bursts, drain and verdict.
	initial begin
		bit first_burst;
		first_burst   = 1'b1;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.op     = ioset_pkg::OP_ADD;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;
		foreach (key_pool[i]) begin
			key_pool[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
		end

		while (beats_sent < DIR_ROWS + RAND_BEATS) begin
			if (first_burst || $urandom_range(99) < 20) begin
				fill_burst();
			end else begin
				mixed_burst();
			end
			first_burst = 1'b0;
		end
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("[insertion_ordered_int_set_core] OK");
		end else begin
			$display("[insertion_ordered_int_set_core] ERROR");
		end
		$finish;
	end

endmodule
